// ===== src/mtbs_pkg.sv =====
package mtbs_pkg;

	localparam int RUN_MAX = 8;
	localparam int VLQ_GROUPS = 5;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_EVENT = 2'd1,
		OP_END   = 2'd2
	} op_t;

	typedef enum logic {
		CFG_TEMPO_EN  = 1'b0,
		CFG_TEMPO_VAL = 1'b1
	} cfg_idx_t;

	localparam logic [7:0]  META_PREFIX = 8'hff;
	localparam logic [7:0]  META_TEMPO  = 8'h51;
	localparam logic [7:0]  META_EOT    = 8'h2f;
	localparam logic [7:0]  TEMPO_LEN   = 8'h03;
	localparam logic [23:0] TEMPO_RESET = 24'd500000;

	// one item's worth of body bytes, bytes[0] goes out first
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] bytes;
		logic [3:0]              n;
		logic                    clear;
	} run_t;

endpackage

// ===== src/mtbs_encode.sv =====
module mtbs_encode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           operation,
	input  logic [31:0]          event_tick,
	input  logic [7:0]           status_byte,
	input  logic [7:0]           first_data,
	input  logic [7:0]           second_data,
	input  logic [1:0]           byte_count,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [23:0]          cfg_data,
	output mtbs_pkg::run_t       run_s1,
	output logic                 run_valid_s1,
	input  logic                 run_take
);
	import mtbs_pkg::*;

	logic [31:0] prev_tick_q;
	logic        tempo_en_q;
	logic [23:0] tempo_q;
	logic [31:0] delta;
	logic [6:0]  grp [VLQ_GROUPS];
	logic [2:0]  nv;
	run_t        run_d;
	logic        accept;

	assign in_ready = !run_valid_s1 || run_take;
	assign accept   = in_valid && in_ready;

	always_comb begin
		logic [3:0] kk;
		logic [3:0] j;
		logic [2:0] gi;
		kk    = '0;
		j     = '0;
		gi    = '0;
		delta = event_tick - prev_tick_q;
		for (int i = 0; i < VLQ_GROUPS; i++) begin
			grp[i] = 7'(delta >> (7 * i));
		end
		priority if (delta[31:28] != 4'd0) begin
			nv = 3'd5;
		end else if (delta[27:21] != 7'd0) begin
			nv = 3'd4;
		end else if (delta[20:14] != 7'd0) begin
			nv = 3'd3;
		end else if (delta[13:7] != 7'd0) begin
			nv = 3'd2;
		end else begin
			nv = 3'd1;
		end
		run_d = '0;
		unique case (operation)
			OP_START: begin
				run_d.clear = 1'b1;
				if (tempo_en_q) begin
					run_d.n        = 4'd7;
					run_d.bytes[0] = 8'h00;
					run_d.bytes[1] = META_PREFIX;
					run_d.bytes[2] = META_TEMPO;
					run_d.bytes[3] = TEMPO_LEN;
					run_d.bytes[4] = tempo_q[23:16];
					run_d.bytes[5] = tempo_q[15:8];
					run_d.bytes[6] = tempo_q[7:0];
				end
			end
			OP_EVENT: begin
				run_d.n = {1'b0, nv} + {2'b00, byte_count};
				for (int k = 0; k < RUN_MAX; k++) begin
					kk = 4'(k);
					j  = kk - {1'b0, nv};
					gi = nv - 3'd1 - kk[2:0];
					if (kk < {1'b0, nv}) begin
						run_d.bytes[k] = {(gi != 3'd0), grp[gi]};
					end else if (j < {2'b00, byte_count}) begin
						unique case (j[1:0])
							2'd0:    run_d.bytes[k] = status_byte;
							2'd1:    run_d.bytes[k] = first_data;
							default: run_d.bytes[k] = second_data;
						endcase
					end
				end
			end
			OP_END: begin
				run_d.n        = 4'd4;
				run_d.bytes[0] = 8'h00;
				run_d.bytes[1] = META_PREFIX;
				run_d.bytes[2] = META_EOT;
				run_d.bytes[3] = 8'h00;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_s1 <= 1'b0;
			prev_tick_q  <= '0;
			tempo_en_q   <= 1'b0;
			tempo_q      <= TEMPO_RESET;
		end else begin
			if (accept) begin
				run_valid_s1 <= 1'b1;
				if (operation == OP_START) begin
					prev_tick_q <= '0;
				end else if (operation == OP_EVENT) begin
					prev_tick_q <= event_tick;
				end
			end else if (run_take) begin
				run_valid_s1 <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == CFG_TEMPO_EN) begin
					tempo_en_q <= cfg_data[0];
				end else begin
					tempo_q <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			run_s1 <= run_d;
		end
	end

endmodule

// ===== src/mtbs_emit.sv =====
module mtbs_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  mtbs_pkg::run_t run_s1,
	input  logic           run_valid_s1,
	output logic           run_take,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           last_of_run,
	output logic [31:0]    body_length
);
	import mtbs_pkg::*;

	logic [RUN_MAX-2:0][7:0] buf_q;
	logic [2:0]              rem_q;
	logic [31:0]             total_q;
	logic                    slot_free;
	logic                    from_buf;
	logic                    load_emit;
	logic [31:0]             total_base;
	logic [31:0]             total_next;

	assign slot_free  = !out_valid || out_ready;
	assign from_buf   = slot_free && (rem_q != 3'd0);
	assign run_take   = slot_free && (rem_q == 3'd0) && run_valid_s1;
	assign load_emit  = run_take && (run_s1.n != 4'd0);
	assign total_base = (run_take && run_s1.clear) ? 32'd0 : total_q;
	assign total_next = total_base + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			rem_q     <= '0;
			total_q   <= '0;
		end else if (slot_free) begin
			if (from_buf) begin
				out_valid <= 1'b1;
				rem_q     <= rem_q - 3'd1;
				total_q   <= total_next;
			end else if (load_emit) begin
				out_valid <= 1'b1;
				rem_q     <= 3'(run_s1.n - 4'd1);
				total_q   <= total_next;
			end else begin
				out_valid <= 1'b0;
				total_q   <= total_base;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (from_buf) begin
			out_byte    <= buf_q[0];
			last_of_run <= (rem_q == 3'd1);
			body_length <= total_next;
			buf_q       <= buf_q >> 8;
		end else if (load_emit) begin
			out_byte    <= run_s1.bytes[0];
			last_of_run <= (run_s1.n == 4'd1);
			body_length <= total_next;
			buf_q       <= run_s1.bytes[RUN_MAX-1:1];
		end
	end

endmodule

// ===== src/midi_track_body_serializer.sv =====
// Track body serializer: turns track items into the bytes of a track body.
// Input channel (in_valid/in_ready): one transfer per item; operation picks
// start track, timed event or end track. Unused operation code is dropped.
// Output channel (out_valid/out_ready): one transfer per body byte, with
// last_of_run on the final byte of an item and body_length counting bytes
// since the last start. Configuration writes (cfg_we) go to tempo_enable
// (index 0) or tempo_us_per_quarter (index 1); the user must make them
// only while the block is idle, as the block itself does not enforce it.
// The first byte of an item is registered in run_s1, then in out_byte.
// The byte emitter sends one byte per cycle while out_ready is high. An
// item has up to 8 bytes (5 delta bytes plus 3 event bytes).
// A new item is taken while the previous one is still being sent.
// Reset clears previous tick, byte count and config to defaults
// (tempo off, 500000 us per quarter); output goes invalid.
// When the receiver stalls, the current byte holds and the one-item input
// register fills, after which in_ready drops.
module midi_track_body_serializer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] event_tick,
	input  logic [7:0]  status_byte,
	input  logic [7:0]  first_data,
	input  logic [7:0]  second_data,
	input  logic [1:0]  byte_count,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic [31:0] body_length
);
	import mtbs_pkg::*;

	run_t run_s1;
	logic run_valid_s1;
	logic run_take;

	mtbs_encode u_encode (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.event_tick   (event_tick),
		.status_byte  (status_byte),
		.first_data   (first_data),
		.second_data  (second_data),
		.byte_count   (byte_count),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.run_s1       (run_s1),
		.run_valid_s1 (run_valid_s1),
		.run_take     (run_take)
	);

	mtbs_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.run_s1       (run_s1),
		.run_valid_s1 (run_valid_s1),
		.run_take     (run_take),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run),
		.body_length  (body_length)
	);

endmodule

// ===== src/mtbs_check.sv =====
module mtbs_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic        last_of_run,
	input logic [31:0] body_length
);

	// stalled output transfer holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(last_of_run) && $stable(body_length))
		else $error("output changed while stalled");

	// bytes inside one item are counted without gaps
	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run
			|=> !out_valid || body_length == $past(body_length) + 32'd1)
		else $error("body length skipped within an item");

	// with no byte pending the input side is never blocked
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked while output idle");

endmodule

bind midi_track_body_serializer mtbs_check u_check (.*);

// ===== verif/tb_midi_track_body_serializer.sv =====
module tb_midi_track_body_serializer;
	import mtbs_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_ITEMS = 70;

	typedef struct packed {
		logic [7:0]  value;
		logic        run_end;
		logic [31:0] length;
	} body_byte_t;

	// typed bytes are left-aligned: the first byte out sits in typed[7]
	typedef struct packed {
		logic            is_cfg;
		cfg_idx_t        reg_idx;
		logic [23:0]     reg_val;
		logic [1:0]      op;
		logic [31:0]     tick;
		logic [7:0]      b0;
		logic [7:0]      b1;
		logic [7:0]      b2;
		logic [1:0]      cnt;
		logic [3:0]      n_typed;
		logic [31:0]     len0;
		logic [7:0][7:0] typed;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [25] = '{
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_END, 32'h0, 8'h00, 8'h00, 8'h00, 2'd0,
			4'd4, 32'd1, 64'h00ff_2f00_0000_0000},
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_EVENT, 32'h0, 8'hff, 8'hff, 8'hff, 2'd0,
			4'd1, 32'd5, 64'h0},
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_UNUSED, 32'hffff_ffff, 8'hff, 8'hff, 8'hff, 2'd3,
			4'd0, 32'd0, 64'h0},
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_START, 32'hffff_ffff, 8'hff, 8'hff, 8'hff, 2'd3,
			4'd0, 32'd0, 64'h0},
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_EVENT, 32'hffff_ffff, 8'hff, 8'hff, 8'hff, 2'd3,
			4'd8, 32'd1, 64'h8fff_ffff_7fff_ffff},
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_EVENT, 32'h0, 8'h00, 8'h00, 8'h00, 2'd1,
			4'd2, 32'd9, 64'h0100_0000_0000_0000},
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_EVENT, 32'h0000_3fff, 8'h90, 8'h3c, 8'h00, 2'd2,
			4'd0, 32'd0, 64'h0},
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_EVENT, 32'h0000_7fff, 8'h90, 8'h3c, 8'h7f, 2'd3,
			4'd0, 32'd0, 64'h0},
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_EVENT, 32'h0022_7ffe, 8'hc0, 8'h05, 8'h00, 2'd1,
			4'd0, 32'd0, 64'h0},
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_EVENT, 32'h0042_7ffe, 8'hb0, 8'h07, 8'h00, 2'd2,
			4'd0, 32'd0, 64'h0},
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_EVENT, 32'h1042_7ffd, 8'he0, 8'h7f, 8'h7f, 2'd3,
			4'd0, 32'd0, 64'h0},
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_EVENT, 32'h2042_7ffd, 8'h00, 8'h00, 8'h00, 2'd0,
			4'd0, 32'd0, 64'h0},
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_EVENT, 32'h2042_7ffd, 8'h80, 8'h00, 8'h00, 2'd3,
			4'd0, 32'd0, 64'h0},
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_END, 32'h0, 8'h00, 8'h00, 8'h00, 2'd0,
			4'd0, 32'd0, 64'h0},
		'{1'b1, CFG_TEMPO_VAL, 24'h0, OP_START, 32'h0, 8'h00, 8'h00, 8'h00, 2'd0,
			4'd0, 32'd0, 64'h0},
		'{1'b1, CFG_TEMPO_EN, 24'h1, OP_START, 32'h0, 8'h00, 8'h00, 8'h00, 2'd0,
			4'd0, 32'd0, 64'h0},
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_START, 32'h0, 8'h00, 8'h00, 8'h00, 2'd0,
			4'd7, 32'd1, 64'h00ff_5103_0000_0000},
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_EVENT, 32'h0000_0080, 8'h90, 8'h40, 8'h7f, 2'd3,
			4'd0, 32'd0, 64'h0},
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_END, 32'h0, 8'h00, 8'h00, 8'h00, 2'd0,
			4'd0, 32'd0, 64'h0},
		'{1'b1, CFG_TEMPO_VAL, 24'hff_ffff, OP_START, 32'h0, 8'h00, 8'h00, 8'h00, 2'd0,
			4'd0, 32'd0, 64'h0},
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_START, 32'h0, 8'h00, 8'h00, 8'h00, 2'd0,
			4'd7, 32'd1, 64'h00ff_5103_ffff_ff00},
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_END, 32'h0, 8'h00, 8'h00, 8'h00, 2'd0,
			4'd4, 32'd8, 64'h00ff_2f00_0000_0000},
		'{1'b1, CFG_TEMPO_VAL, TEMPO_RESET, OP_START, 32'h0, 8'h00, 8'h00, 8'h00, 2'd0,
			4'd0, 32'd0, 64'h0},
		'{1'b0, CFG_TEMPO_EN, 24'h0, OP_START, 32'h0, 8'h00, 8'h00, 8'h00, 2'd0,
			4'd7, 32'd1, 64'h00ff_5103_07a1_2000},
		'{1'b1, CFG_TEMPO_EN, 24'h0, OP_START, 32'h0, 8'h00, 8'h00, 8'h00, 2'd0,
			4'd0, 32'd0, 64'h0}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = OP_START;
	logic [31:0] event_tick = '0;
	logic [7:0]  status_byte = '0;
	logic [7:0]  first_data = '0;
	logic [7:0]  second_data = '0;
	logic [1:0]  byte_count = '0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_TEMPO_EN;
	logic [23:0] cfg_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        last_of_run;
	logic [31:0] body_length;

	midi_track_body_serializer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.event_tick (event_tick),
		.status_byte(status_byte),
		.first_data (first_data),
		.second_data(second_data),
		.byte_count (byte_count),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last_of_run(last_of_run),
		.body_length(body_length)
	);

	// track encoder model state
	logic        tempo_on = 1'b0;
	logic [23:0] tempo_us = TEMPO_RESET;
	logic [31:0] trk_prev_tick = '0;
	logic [31:0] trk_total = '0;

	body_byte_t run_q[$];
	body_byte_t body_q[$];

	int err_cnt = 0;
	int item_cnt = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	bit hold_req = 1'b0;
	int stall_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void emit_byte(logic [7:0] b);
		body_byte_t r;
		trk_total = trk_total + 32'd1;
		r.value = b;
		r.run_end = 1'b0;
		r.length = trk_total;
		run_q = {run_q, r};
	endfunction

	function automatic void encode_delta(logic [31:0] d);
		logic [6:0] grp[5];
		int ng;
		ng = 1;
		grp[0] = d[6:0];
		d = d >> 7;
		while (d != 0) begin
			grp[ng] = d[6:0];
			ng++;
			d = d >> 7;
		end
		for (int i = ng - 1; i >= 0; i--) begin
			emit_byte({i != 0, grp[i]});
		end
	endfunction

	function automatic void serialize_item(logic [1:0] op, logic [31:0] tick,
		logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [1:0] cnt);
		run_q.delete();
		if (op == OP_START) begin
			trk_prev_tick = '0;
			trk_total = '0;
			if (tempo_on) begin
				emit_byte(8'h00);
				emit_byte(META_PREFIX);
				emit_byte(META_TEMPO);
				emit_byte(TEMPO_LEN);
				emit_byte(tempo_us[23:16]);
				emit_byte(tempo_us[15:8]);
				emit_byte(tempo_us[7:0]);
			end
		end else if (op == OP_EVENT) begin
			encode_delta(tick - trk_prev_tick);
			if (cnt >= 2'd1) emit_byte(b0);
			if (cnt >= 2'd2) emit_byte(b1);
			if (cnt >= 2'd3) emit_byte(b2);
			trk_prev_tick = tick;
		end else if (op == OP_END) begin
			emit_byte(8'h00);
			emit_byte(META_PREFIX);
			emit_byte(META_EOT);
			emit_byte(8'h00);
		end
		if (run_q.size() > 0) run_q[run_q.size() - 1].run_end = 1'b1;
	endfunction

	task automatic push_item(logic [1:0] op, logic [31:0] tick, logic [7:0] b0,
		logic [7:0] b1, logic [7:0] b2, logic [1:0] cnt, logic [3:0] n_typed,
		logic [31:0] len0, logic [7:0][7:0] typed);
		body_byte_t e;
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		event_tick <= tick;
		status_byte <= b0;
		first_data <= b1;
		second_data <= b2;
		byte_count <= cnt;
		do @(posedge clk); while (!in_ready);
		serialize_item(op, tick, b0, b1, b2, cnt);
		if (n_typed != 0) begin
			for (int i = 0; i < n_typed; i++) begin
				e.value = typed[7 - i];
				e.run_end = (i == n_typed - 1);
				e.length = len0 + i;
				body_q = {body_q, e};
			end
		end else begin
			foreach (run_q[i]) body_q = {body_q, run_q[i]};
		end
		if (op != OP_UNUSED) item_cnt++;
	endtask

	task automatic push_rand(logic [1:0] op, logic [31:0] tick, logic [1:0] cnt);
		push_item(op, tick, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), cnt, 4'd0, 32'd0, 64'h0);
	endtask

	// sender pause: wait for every pending byte, then let the block settle
	task automatic drain_body();
		in_valid <= 1'b0;
		while (body_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == CFG_TEMPO_EN) tempo_on = val[0];
		else tempo_us = val;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic gen_track();
		logic [31:0] tick;
		logic [63:0] mask;
		int n_ev;
		int k;
		tick = '0;
		if ($urandom_range(5) != 0) push_rand(OP_START, $urandom, 2'($urandom_range(3)));
		n_ev = $urandom_range(8);
		for (int i = 0; i < n_ev; i++) begin
			case ($urandom_range(9))
				0: begin
					push_rand(OP_UNUSED, $urandom, 2'($urandom_range(3)));
				end
				1: begin
					tick = $urandom;
					push_rand(OP_EVENT, tick, 2'($urandom_range(3)));
				end
				default: begin
					k = $urandom_range(4);
					mask = (64'd1 << (7 * k + 7)) - 64'd1;
					tick = tick + ($urandom & mask[31:0]);
					push_rand(OP_EVENT, tick, 2'($urandom_range(1, 3)));
				end
			endcase
		end
		if ($urandom_range(7) != 0) push_rand(OP_END, $urandom, 2'($urandom_range(3)));
	endtask

	always @(posedge clk) begin
		int hold_left;
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		body_byte_t e;
		if (out_valid && out_ready) begin
			if (body_q.size() == 0) begin
				$error("unexpected transfer: out_byte %h last_of_run %b body_length %0d",
					out_byte, last_of_run, body_length);
				err_cnt++;
			end else begin
				e = body_q.pop_front();
				if (out_byte !== e.value) begin
					$error("out_byte expected %h actual %h", e.value, out_byte);
					err_cnt++;
				end
				if (last_of_run !== e.run_end) begin
					$error("last_of_run expected %b actual %b", e.run_end, last_of_run);
					err_cnt++;
				end
				if (body_length !== e.length) begin
					$error("body_length expected %0d actual %0d", e.length, body_length);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_midi_track_body_serializer: FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		dir_row_t row;
		int target;
		bit paused;
		paused = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle_pct = 23;
		rcv_idle_pct = 55;
		for (int r = 0; r < 25; r++) begin
			row = DIR_ROWS[r];
			if (row.is_cfg) begin
				drain_body();
				write_reg(row.reg_idx, row.reg_val);
			end else begin
				push_item(row.op, row.tick, row.b0, row.b1, row.b2, row.cnt,
					row.n_typed, row.len0, row.typed);
			end
		end

		for (int ph = 0; ph < 3; ph++) begin
			drain_body();
			case (ph)
				0: begin
					snd_idle_pct = 23;
					rcv_idle_pct = 55;
					write_reg(CFG_TEMPO_VAL, 24'($urandom_range(24'hff_ffff)));
					write_reg(CFG_TEMPO_EN, 24'h1);
				end
				1: begin
					snd_idle_pct = 55;
					rcv_idle_pct = 23;
					write_reg(CFG_TEMPO_EN, 24'h0);
					write_reg(CFG_TEMPO_VAL, 24'($urandom_range(24'hff_ffff)));
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
					write_reg(CFG_TEMPO_VAL, 24'($urandom_range(24'hff_ffff)));
					write_reg(CFG_TEMPO_EN, 24'h1);
				end
			endcase
			// long receiver stall while the sender keeps offering items
			if (ph == 0) hold_req = 1'b1;
			target = item_cnt + PHASE_ITEMS;
			while (item_cnt < target) begin
				gen_track();
				if (ph == 1 && !paused && item_cnt >= target - PHASE_ITEMS / 2) begin
					drain_body();
					paused = 1'b1;
				end
			end
		end

		drain_body();
		if (err_cnt == 0) begin
			$display("tb_midi_track_body_serializer: PASS");
		end else begin
			$display("tb_midi_track_body_serializer: FAIL");
		end
		$finish;
	end

endmodule
